/* src/hs_pkg.sv */
// ----------------------------------------------------------------------------
// hs_pkg
// Shared widths, defaults and the per-cycle broadcast type of the heap sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package hs_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DEPTH_DEF = 64;

  // Command broadcast from the control logic to every cell in the chain
  typedef struct packed {
    logic                     ins;    // insert x into the sorted chain
    logic                     shift;  // move every value one cell toward the head
    logic signed [DATA_W-1:0] x;      // value being inserted
  } hs_bcast_t;

endpackage

`default_nettype wire

/* src/hs_in_if.sv */
// ----------------------------------------------------------------------------
// hs_in_if
// Input channel: one value per transaction, last marks the end of a batch.
// ----------------------------------------------------------------------------
`default_nettype none

interface hs_in_if
  import hs_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

/* src/hs_out_if.sv */
// ----------------------------------------------------------------------------
// hs_out_if
// Output channel: sorted values in ascending order with batch status.
// ----------------------------------------------------------------------------
`default_nettype none

interface hs_out_if
  import hs_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     final_res;
  logic                     dropped;

  modport source (output valid, output sorted_value, output final_res,
                  output dropped, input ready);
  modport sink   (input valid, input sorted_value, input final_res,
                  input dropped, output ready);
endinterface

`default_nettype wire

/* src/hs_cell.sv */
// ----------------------------------------------------------------------------
// hs_cell
// One cell of the sorting chain: holds one value, compares it against the
// broadcast value and either keeps it, takes the new value, or takes the
// value of a neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module hs_cell
  import hs_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire hs_bcast_t                ctl_i,
  input  wire logic                     occ_i,
  input  wire logic                     left_gt_i,
  input  wire logic signed [DATA_W-1:0] left_val_i,
  input  wire logic signed [DATA_W-1:0] right_val_i,
  output logic                          gt_o,
  output logic signed [DATA_W-1:0]      val_o
);

  logic signed [DATA_W-1:0] val_q;
  logic signed [DATA_W-1:0] val_d;

  // An empty cell acts as plus infinity so new values land at the tail
  assign gt_o  = !occ_i || (val_q > ctl_i.x);
  assign val_o = val_q;

  // Insert: the first cell above x takes x, later ones take the left value.
  // Drain: take the value of the right neighbor.
  always_comb begin
    val_d = val_q;
    if (ctl_i.ins && gt_o) begin
      val_d = left_gt_i ? left_val_i : ctl_i.x;
    end else if (ctl_i.shift) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

/* src/heap_sorter_top.sv */
// The smallest value is offered in the cycle after the last item is taken.
// Loading takes one item per cycle; draining gives one result per cycle while the output is ready;
// input is held off while draining.
// The rate is set by the chain of compare cells, one insert or one shift per cycle.
// Reset clears the fill count, the overflow flag and the drain state; cell data is not reset.
// ----------------------------------------------------------------------------
// heap_sorter_top
// Batch sorter built as a chain of cells kept in ascending order on insert;
// results stream out of the head of the chain, marking the final one.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sorter_top
  import hs_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hs_in_if.sink     in_i,
  hs_out_if.source  out_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic             drain_q, drain_d;
  logic             drop_q, drop_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             in_acc, out_acc, full;
  hs_bcast_t        ctl;

  logic                     gt   [DEPTH];
  logic signed [DATA_W-1:0] vals [DEPTH];

  assign full    = (count_q == CNT_W'(DEPTH));
  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  assign in_i.ready          = !drain_q;
  assign out_o.valid         = drain_q;
  assign out_o.sorted_value  = vals[0];
  assign out_o.final_res     = (count_q == CNT_W'(1));
  assign out_o.dropped       = drop_q;

  // Broadcast command to the chain
  always_comb begin
    ctl.ins   = in_acc && !full;
    ctl.shift = out_acc;
    ctl.x     = in_i.value;
  end

  // Fill count, overflow flag and drain state
  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    drain_d = drain_q;
    if (in_acc) begin
      if (full) begin
        drop_d = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
      if (in_i.last) begin
        drain_d = 1'b1;
      end
    end else if (out_acc) begin
      count_d = count_q - CNT_W'(1);
      if (count_q == CNT_W'(1)) begin
        drain_d = 1'b0;
        drop_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
      drain_q <= 1'b0;
    end else begin
      count_q <= count_d;
      drop_q  <= drop_d;
      drain_q <= drain_d;
    end
  end

  // Chain of cells, head holds the smallest value
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     occ;
    logic                     left_gt;
    logic signed [DATA_W-1:0] left_val;
    logic signed [DATA_W-1:0] right_val;

    assign occ = (count_q > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_gt  = 1'b0;
      assign left_val = '0;
    end else begin : g_body
      assign left_gt  = gt[i-1];
      assign left_val = vals[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = vals[i+1];
    end

    hs_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occ_i       (occ),
      .left_gt_i   (left_gt),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .gt_o        (gt[i]),
      .val_o       (vals[i])
    );
  end

endmodule

`default_nettype wire
